### hdl/heu_pkg.sv
package heu_pkg;

   localparam int NameMax = 4;
   localparam int ResMax  = 6;

   typedef logic [7:0] char_type;
   typedef logic [2:0] count_type;

   localparam char_type CHAR_AMP   = 8'h26;  // '&'
   localparam char_type CHAR_SEMI  = 8'h3B;  // ';'
   localparam char_type CHAR_QUOT  = 8'h22;  // '"'
   localparam char_type CHAR_LT    = 8'h3C;  // '<'
   localparam char_type CHAR_GT    = 8'h3E;  // '>'
   localparam char_type CHAR_APOS  = 8'h27;  // '\''

   localparam count_type NAME_MAX_CNT = 3'd4;

   // entity names, first character in the lowest byte
   localparam logic [23:0] NAME_AMP  = {8'h70, 8'h6D, 8'h61};         // "amp"
   localparam logic [31:0] NAME_QUOT = {8'h74, 8'h6F, 8'h75, 8'h71};  // "quot"
   localparam logic [15:0] NAME_LT   = {8'h74, 8'h6C};                // "lt"
   localparam logic [15:0] NAME_GT   = {8'h74, 8'h67};                // "gt"
   localparam logic [31:0] NAME_APOS = {8'h73, 8'h6F, 8'h70, 8'h61};  // "apos"

   typedef struct packed {
      logic [ResMax-1:0][7:0] chars;
      count_type              count;
      logic                   str_last;
   } result_type;

endpackage

### hdl/html_entity_unescape_unit.sv
// a request is held in the request register, then loaded into the result shift
//    register; one request per cycle while each request gives at most one byte
//    and rsp_tready is high; a request that gives more bytes holds back the next
//    one (one byte leaves the shift register per cycle while rsp_tready is high)
// reset: synchronous, active high; clears the entity state and both valid stages
module html_entity_unescape_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // in_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [0:0]  rsp_tuser,   // [0] run_last
   output logic        rsp_tlast    // string_last
);

   // request register
   logic                req_valid_ff;
   heu_pkg::char_type   req_char_ff;
   logic                req_last_ff;

   heu_pkg::result_type result;
   logic                emit_free;
   logic                step;
   logic                load;

   // a request with no result byte retires without waiting for the emitter
   assign step       = req_valid_ff && (result.count == '0 || emit_free);
   assign load       = step && (result.count != '0);
   assign req_tready = !req_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_char_ff <= req_tdata;
         req_last_ff <= req_tlast;
      end
   end

   // entity tracking and result list
   heu_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_char (req_char_ff),
      .in_last (req_last_ff),
      .result  (result)
   );

   // result shift register, one byte per handshake
   heu_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .result       (result),
      .free         (emit_free),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_char     (rsp_tdata),
      .out_run_last (rsp_tuser[0]),
      .out_str_last (rsp_tlast)
   );

endmodule

### hdl/heu_scan.sv
module heu_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  heu_pkg::char_type     in_char,
   input  logic                  in_last,
   output heu_pkg::result_type   result
);

   logic                           in_entity_ff, in_entity_in;
   heu_pkg::count_type             name_count_ff, name_count_in;
   logic [heu_pkg::NameMax-1:0][7:0] name_ff;
   logic                           name_we;

   logic [heu_pkg::NameMax-1:0][7:0] names_w;
   heu_pkg::count_type             flush_cnt;
   logic                           flush_on, has_tail, single_on;
   heu_pkg::char_type              tail_char, single_char, repl_char;
   logic                           is_amp, is_semi, known;

   assign is_amp  = (in_char == heu_pkg::CHAR_AMP);
   assign is_semi = (in_char == heu_pkg::CHAR_SEMI);

   // name lookup against the held bytes
   always_comb begin
      repl_char = heu_pkg::CHAR_AMP;
      known     = 1'b1;
      if (name_count_ff == 3'd3 && name_ff[2:0] == heu_pkg::NAME_AMP) begin
         repl_char = heu_pkg::CHAR_AMP;
      end else if (name_count_ff == 3'd4 && name_ff == heu_pkg::NAME_QUOT) begin
         repl_char = heu_pkg::CHAR_QUOT;
      end else if (name_count_ff == 3'd2 && name_ff[1:0] == heu_pkg::NAME_LT) begin
         repl_char = heu_pkg::CHAR_LT;
      end else if (name_count_ff == 3'd2 && name_ff[1:0] == heu_pkg::NAME_GT) begin
         repl_char = heu_pkg::CHAR_GT;
      end else if (name_count_ff == 3'd4 && name_ff == heu_pkg::NAME_APOS) begin
         repl_char = heu_pkg::CHAR_APOS;
      end else begin
         known = 1'b0;
      end
   end

   always_comb begin
      names_w       = name_ff;
      name_we       = 1'b0;
      flush_on      = 1'b0;
      flush_cnt     = name_count_ff;
      has_tail      = 1'b0;
      tail_char     = in_char;
      single_on     = 1'b0;
      single_char   = in_char;
      in_entity_in  = in_entity_ff;
      name_count_in = name_count_ff;

      if (!in_entity_ff) begin
         if (is_amp) begin
            in_entity_in  = 1'b1;
            name_count_in = '0;
            flush_cnt     = '0;
            flush_on      = in_last;
         end else begin
            single_on = 1'b1;
         end
      end else if (is_amp) begin
         // nested ampersand flushes and restarts the candidate
         flush_on      = 1'b1;
         has_tail      = in_last;
         tail_char     = heu_pkg::CHAR_AMP;
         name_count_in = '0;
      end else if (is_semi) begin
         if (known) begin
            single_on   = 1'b1;
            single_char = repl_char;
         end else begin
            flush_on = 1'b1;
            has_tail = 1'b1;
         end
         in_entity_in  = 1'b0;
         name_count_in = '0;
      end else if (name_count_ff < heu_pkg::NAME_MAX_CNT) begin
         names_w[name_count_ff[1:0]] = in_char;
         name_we       = 1'b1;
         name_count_in = name_count_ff + 3'd1;
         flush_cnt     = name_count_ff + 3'd1;
         flush_on      = in_last;
      end else begin
         // name too long
         flush_on      = 1'b1;
         has_tail      = 1'b1;
         in_entity_in  = 1'b0;
         name_count_in = '0;
      end

      if (in_last) begin
         in_entity_in  = 1'b0;
         name_count_in = '0;
      end
   end

   // result list: a single byte, or '&', held names, optional tail
   always_comb begin
      result          = '0;
      result.str_last = in_last;
      result.chars[0] = heu_pkg::CHAR_AMP;
      for (int i = 1; i < heu_pkg::ResMax - 1; i++) begin
         result.chars[i] = (3'(i - 1) < flush_cnt) ? names_w[i-1] : tail_char;
      end
      result.chars[heu_pkg::ResMax-1] = tail_char;
      if (single_on) begin
         result.chars[0] = single_char;
         result.count    = 3'd1;
      end else if (flush_on) begin
         result.count = 3'd1 + flush_cnt + {2'b00, has_tail};
      end else begin
         result.count = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_entity_ff  <= 1'b0;
         name_count_ff <= '0;
      end else if (step) begin
         in_entity_ff  <= in_entity_in;
         name_count_ff <= name_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && name_we) begin
         name_ff <= names_w;
      end
   end

endmodule

### hdl/heu_emit.sv
module heu_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  heu_pkg::result_type result,
   output logic                free,
   output logic                out_valid,
   input  logic                out_ready,
   output heu_pkg::char_type   out_char,
   output logic                out_run_last,
   output logic                out_str_last
);

   logic [heu_pkg::ResMax-1:0][7:0] chars_ff;
   heu_pkg::count_type              count_ff;
   logic                            str_last_ff;
   logic                            take;

   assign out_valid    = (count_ff != '0);
   assign take         = out_valid && out_ready;
   assign free         = (count_ff == '0) || (count_ff == 3'd1 && out_ready);
   assign out_char     = chars_ff[0];
   assign out_run_last = (count_ff == 3'd1);
   assign out_str_last = (count_ff == 3'd1) && str_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= result.count;
      end else if (take) begin
         count_ff <= count_ff - 3'd1;
      end
   end

   // shift register: head byte is always the one on the bus
   always_ff @(posedge clock) begin
      if (load) begin
         chars_ff    <= result.chars;
         str_last_ff <= result.str_last;
      end else if (take) begin
         for (int i = 0; i < heu_pkg::ResMax - 1; i++) begin
            chars_ff[i] <= chars_ff[i+1];
         end
      end
   end

endmodule
